// ----- rtl/frdq_pkg.sv -----
`timescale 1ns / 1ps

package frdq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;

  localparam int FRAME_W  = 31;
  localparam int OWNER_W  = 8;
  localparam int REGION_W = 40;
  localparam int GATE_W   = 32;
  localparam int WAIT_W   = 8;

  localparam logic [WAIT_W-1:0] WAIT_FRAMES_RST = 8'd2;

  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WAIT_FRAMES = 2'd0;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_ACK     = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic capture;    // latch the incoming transaction
    logic pop_emit;   // release head entry to the output register
    logic set_gate;   // head too young: move the gate past it
    logic append_ack; // append request (if room) and emit acknowledgment
  } frdq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic gate_open;
    logic q_empty;
    logic head_old;
    logic out_free;
  } frdq_status_t;

endpackage

// ----- rtl/frame_deferred_release_queue_unit.sv -----
`timescale 1ns / 1ps

// Deferred release queue for freed memory regions, fenced by frame number.
// Input channel (in_*): one free request per transaction - current frame,
// owner, offset, size. Accepted when in_valid is high and in_stall low.
// Result channel (out_*): zero or more release transactions (out_kind = 0),
// oldest first, then one acknowledgment (out_kind = 1, out_last = 1) whose
// out_queue_full says whether the request was dropped for lack of room.
// Configuration: APB-style port, wait_frames at byte address 0.
// Sequence: one request is in flight at a time. After the accept the block
// checks the head entry; each released entry is emitted, then the new head
// is re-read from the store's registered read port before the next check.
// Last come the append and the acknowledgment. A new request is accepted
// only after the acknowledgment is written to the output register.
// Results sit in an output register; out_stall freezes it and the
// controller waits, so nothing is lost or repeated.
// Reset (rst_n low, synchronous): queue empty, release gate 0,
// wait_frames 2, no result pending. Store contents are not cleared.

module frame_deferred_release_queue_unit #(
  parameter int QUEUE_DEPTH = frdq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [frdq_pkg::FRAME_W-1:0]        in_frame_number,
  input  logic [frdq_pkg::OWNER_W-1:0]        in_owner_id,
  input  logic [frdq_pkg::REGION_W-1:0]       in_region_offset,
  input  logic [frdq_pkg::REGION_W-1:0]       in_region_size,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_kind,
  output logic [frdq_pkg::OWNER_W-1:0]        out_owner,
  output logic [frdq_pkg::REGION_W-1:0]       out_offset,
  output logic [frdq_pkg::REGION_W-1:0]       out_size,
  output logic                                out_queue_full,
  output logic                                out_last,
  // configuration port
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [frdq_pkg::CFG_ADDR_W-1:0]     cfg_paddr,
  input  logic [frdq_pkg::CFG_DATA_W-1:0]     cfg_pwdata,
  output logic [frdq_pkg::CFG_DATA_W-1:0]     cfg_prdata,
  output logic                                cfg_pready
);

  frdq_pkg::frdq_cmd_t          cmd;
  frdq_pkg::frdq_status_t       sts;
  logic                         wait_wr;
  logic [frdq_pkg::WAIT_W-1:0]  wait_frames;
  logic                         addr_hit;

  // register decode: only wait_frames exists, other addresses ignored
  assign addr_hit   = (cfg_paddr == frdq_pkg::ADDR_WAIT_FRAMES);
  assign wait_wr    = cfg_psel && cfg_penable && cfg_pwrite && addr_hit;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = addr_hit ? frdq_pkg::CFG_DATA_W'(wait_frames) : '0;

  frdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  frdq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_frame_number  (in_frame_number),
    .in_owner_id      (in_owner_id),
    .in_region_offset (in_region_offset),
    .in_region_size   (in_region_size),
    .wait_wr          (wait_wr),
    .wait_wdata       (cfg_pwdata[frdq_pkg::WAIT_W-1:0]),
    .wait_frames      (wait_frames),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_owner        (out_owner),
    .out_offset       (out_offset),
    .out_size         (out_size),
    .out_queue_full   (out_queue_full),
    .out_last         (out_last)
  );

endmodule

// ----- rtl/frdq_ctrl.sv -----
`timescale 1ns / 1ps

module frdq_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  frdq_pkg::frdq_status_t sts,
  output frdq_pkg::frdq_cmd_t    cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_REREAD,
    ST_APPEND
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_stall_nxt = in_stall_r;
    cmd          = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid && !in_stall_r) begin
          cmd.capture  = 1'b1;
          in_stall_nxt = 1'b1;
          state_nxt    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!sts.gate_open || sts.q_empty) begin
          state_nxt = ST_APPEND;
        end else if (sts.head_old) begin
          if (sts.out_free) begin
            cmd.pop_emit = 1'b1;
            state_nxt    = ST_REREAD;
          end
        end else begin
          cmd.set_gate = 1'b1;
          state_nxt    = ST_APPEND;
        end
      end
      ST_REREAD: begin
        // the store reads the new head this cycle; its data is registered for ST_CHECK
        state_nxt = ST_CHECK;
      end
      ST_APPEND: begin
        if (sts.out_free) begin
          cmd.append_ack = 1'b1;
          in_stall_nxt   = 1'b0;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_stall_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= in_stall_nxt;
    end
  end

  assign in_stall = in_stall_r;

endmodule

// ----- rtl/frdq_datapath.sv -----
`timescale 1ns / 1ps

module frdq_datapath #(
  parameter int QUEUE_DEPTH = frdq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // captured request
  input  logic [frdq_pkg::FRAME_W-1:0]       in_frame_number,
  input  logic [frdq_pkg::OWNER_W-1:0]       in_owner_id,
  input  logic [frdq_pkg::REGION_W-1:0]      in_region_offset,
  input  logic [frdq_pkg::REGION_W-1:0]      in_region_size,
  // configuration
  input  logic                               wait_wr,
  input  logic [frdq_pkg::WAIT_W-1:0]        wait_wdata,
  output logic [frdq_pkg::WAIT_W-1:0]        wait_frames,
  // control
  input  frdq_pkg::frdq_cmd_t                cmd,
  output frdq_pkg::frdq_status_t             sts,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_kind,
  output logic [frdq_pkg::OWNER_W-1:0]       out_owner,
  output logic [frdq_pkg::REGION_W-1:0]      out_offset,
  output logic [frdq_pkg::REGION_W-1:0]      out_size,
  output logic                               out_queue_full,
  output logic                               out_last
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  // pending-entry store
  logic [frdq_pkg::FRAME_W-1:0]  mem_frame  [QUEUE_DEPTH];
  logic [frdq_pkg::OWNER_W-1:0]  mem_owner  [QUEUE_DEPTH];
  logic [frdq_pkg::REGION_W-1:0] mem_offset [QUEUE_DEPTH];
  logic [frdq_pkg::REGION_W-1:0] mem_size   [QUEUE_DEPTH];

  logic [frdq_pkg::FRAME_W-1:0]  rd_frame_r;
  logic [frdq_pkg::OWNER_W-1:0]  rd_owner_r;
  logic [frdq_pkg::REGION_W-1:0] rd_offset_r;
  logic [frdq_pkg::REGION_W-1:0] rd_size_r;

  // captured request (payload, no reset)
  logic [frdq_pkg::FRAME_W-1:0]  req_frame_r;
  logic [frdq_pkg::OWNER_W-1:0]  req_owner_r;
  logic [frdq_pkg::REGION_W-1:0] req_offset_r;
  logic [frdq_pkg::REGION_W-1:0] req_size_r;

  logic [IDX_W-1:0]              head_r, head_nxt;
  logic [IDX_W-1:0]              tail_r, tail_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [frdq_pkg::GATE_W-1:0]   gate_r, gate_nxt;
  logic [frdq_pkg::WAIT_W-1:0]   wait_r, wait_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_kind_r;
  logic [frdq_pkg::OWNER_W-1:0]  out_owner_r;
  logic [frdq_pkg::REGION_W-1:0] out_offset_r;
  logic [frdq_pkg::REGION_W-1:0] out_size_r;
  logic                          out_full_r;
  logic                          out_last_r;

  logic [frdq_pkg::GATE_W-1:0]   head_expiry;
  logic [frdq_pkg::GATE_W-1:0]   now_ext;
  logic                          q_full;
  logic                          do_write;
  logic                          out_free;

  assign now_ext     = {1'b0, req_frame_r};
  // head frame + wait, no wrap in 32 bits
  assign head_expiry = {1'b0, rd_frame_r} + frdq_pkg::GATE_W'(wait_r);
  assign q_full      = (count_r == CNT_FULL);
  assign do_write    = cmd.append_ack && !q_full;
  assign out_free    = !out_valid_r || !out_stall;

  assign sts.gate_open = (now_ext >= gate_r);
  assign sts.q_empty   = (count_r == '0);
  assign sts.head_old  = (head_expiry < now_ext);
  assign sts.out_free  = out_free;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    gate_nxt  = gate_r;
    wait_nxt  = wait_r;
    if (cmd.pop_emit) begin
      head_nxt  = (head_r == IDX_LAST) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end
    if (do_write) begin
      tail_nxt  = (tail_r == IDX_LAST) ? '0 : tail_r + 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.set_gate) begin
      gate_nxt = head_expiry + 1'b1;
    end
    if (wait_wr) begin
      wait_nxt = wait_wdata;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.pop_emit || cmd.append_ack) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      gate_r      <= '0;
      wait_r      <= frdq_pkg::WAIT_FRAMES_RST;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      count_r     <= count_nxt;
      gate_r      <= gate_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // store: one write port at the tail, registered read at the head
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem_frame[tail_r]  <= req_frame_r;
      mem_owner[tail_r]  <= req_owner_r;
      mem_offset[tail_r] <= req_offset_r;
      mem_size[tail_r]   <= req_size_r;
    end
    rd_frame_r  <= mem_frame[head_r];
    rd_owner_r  <= mem_owner[head_r];
    rd_offset_r <= mem_offset[head_r];
    rd_size_r   <= mem_size[head_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_frame_r  <= in_frame_number;
      req_owner_r  <= in_owner_id;
      req_offset_r <= in_region_offset;
      req_size_r   <= in_region_size;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_emit) begin
      out_kind_r   <= frdq_pkg::KIND_RELEASE;
      out_owner_r  <= rd_owner_r;
      out_offset_r <= rd_offset_r;
      out_size_r   <= rd_size_r;
      out_full_r   <= 1'b0;
      out_last_r   <= 1'b0;
    end else if (cmd.append_ack) begin
      out_kind_r   <= frdq_pkg::KIND_ACK;
      out_owner_r  <= '0;
      out_offset_r <= '0;
      out_size_r   <= '0;
      out_full_r   <= q_full;
      out_last_r   <= 1'b1;
    end
  end

  assign wait_frames    = wait_r;
  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_owner      = out_owner_r;
  assign out_offset     = out_offset_r;
  assign out_size       = out_size_r;
  assign out_queue_full = out_full_r;
  assign out_last       = out_last_r;

endmodule

// ----- tb/tb_frame_deferred_release_queue_unit.sv -----
`timescale 1ns / 1ps

module tb_frame_deferred_release_queue_unit;

  localparam int     FRAME_W       = frdq_pkg::FRAME_W;
  localparam int     OWNER_W       = frdq_pkg::OWNER_W;
  localparam int     REGION_W      = frdq_pkg::REGION_W;
  localparam int     GATE_W        = frdq_pkg::GATE_W;
  localparam int     WAIT_W        = frdq_pkg::WAIT_W;
  localparam int     CFG_ADDR_W    = frdq_pkg::CFG_ADDR_W;
  localparam int     CFG_DATA_W    = frdq_pkg::CFG_DATA_W;

  localparam int     DEPTH         = frdq_pkg::QUEUE_DEPTH_DEF;
  localparam longint FRAME_MAX     = (longint'(1) << FRAME_W) - 1;
  localparam int     CYCLE_LIMIT   = 1_000_000;
  // the block goes idle straight after the acknowledgment; a short margin suffices
  localparam int     SETTLE_CYCLES = 40;
  localparam int     PHASE_ITEMS   = 61;

  // one free request as presented on the input channel
  typedef struct {
    logic [FRAME_W-1:0]  frame;
    logic [OWNER_W-1:0]  owner;
    logic [REGION_W-1:0] offset;
    logic [REGION_W-1:0] size;
    bit                  drain_first; // hold back until every awaited result is in
  } free_req_t;

  // one result transaction
  typedef struct {
    logic                kind;
    logic [OWNER_W-1:0]  owner;
    logic [REGION_W-1:0] offset;
    logic [REGION_W-1:0] size;
    logic                full;
    logic                last;
  } result_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  // request channel
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [FRAME_W-1:0]  in_frame_number  = '0;
  logic [OWNER_W-1:0]  in_owner_id      = '0;
  logic [REGION_W-1:0] in_region_offset = '0;
  logic [REGION_W-1:0] in_region_size   = '0;

  // result channel
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic                out_kind;
  logic [OWNER_W-1:0]  out_owner;
  logic [REGION_W-1:0] out_offset;
  logic [REGION_W-1:0] out_size;
  logic                out_queue_full;
  logic                out_last;

  // configuration port
  logic                  cfg_psel    = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr   = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata  = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  frame_deferred_release_queue_unit #(.QUEUE_DEPTH(DEPTH)) dut (.*);

  // ---------------------------------------------------------------------------
  // Shadow of the block: pending-free FIFO, release gate and wait_frames.
  // ---------------------------------------------------------------------------
  logic [FRAME_W-1:0]  fifo_frame  [DEPTH];
  logic [OWNER_W-1:0]  fifo_owner  [DEPTH];
  logic [REGION_W-1:0] fifo_offset [DEPTH];
  logic [REGION_W-1:0] fifo_size   [DEPTH];
  int                  fifo_head;
  int                  fifo_tail;
  int                  fifo_count;
  logic [GATE_W-1:0]   gate;
  logic [WAIT_W-1:0]   wait_cfg;

  free_req_t free_reqs[$];        // requests not yet offered to the block
  result_t   awaited_results[$];  // releases and acknowledgments still to come
  free_req_t cur_req;             // request currently on the input ports
  result_t   head_result;

  int          mismatches  = 0;
  int unsigned cycle_count = 0;
  longint      frame_now   = 0;

  int burst_left = 1;
  int gap_left   = 0;
  int stall_mode = 0;
  int stall_left = 0;

  function automatic void reset_shadow();
    fifo_head  = 0;
    fifo_tail  = 0;
    fifo_count = 0;
    gate       = '0;
    wait_cfg   = frdq_pkg::WAIT_FRAMES_RST;
  endfunction

  // append one result to the tail of the awaited list
  function automatic void await_result(input result_t res);
    awaited_results.insert(awaited_results.size(), res);
  endfunction

  // Frame fence: if the gate has been reached, release ripe head entries, then
  // append the request (unless full) and close with an acknowledgment.
  function automatic void predict_free(input free_req_t req);
    logic [FRAME_W+1:0] ripe_at;
    bit                 dropped;
    result_t            res;
    if ({1'b0, req.frame} >= gate) begin
      while (fifo_count > 0) begin
        ripe_at = fifo_frame[fifo_head] + wait_cfg;
        if (ripe_at < req.frame) begin
          res = '{frdq_pkg::KIND_RELEASE, fifo_owner[fifo_head],
                  fifo_offset[fifo_head], fifo_size[fifo_head], 1'b0, 1'b0};
          await_result(res);
          fifo_head  = (fifo_head + 1) % DEPTH;
          fifo_count = fifo_count - 1;
        end else begin
          // head still too young: fence the next check just past it
          gate = ripe_at[GATE_W-1:0] + 1'b1;
          break;
        end
      end
    end
    dropped = (fifo_count >= DEPTH);
    if (!dropped) begin
      fifo_frame[fifo_tail]  = req.frame;
      fifo_owner[fifo_tail]  = req.owner;
      fifo_offset[fifo_tail] = req.offset;
      fifo_size[fifo_tail]   = req.size;
      fifo_tail  = (fifo_tail + 1) % DEPTH;
      fifo_count = fifo_count + 1;
    end
    res = '{frdq_pkg::KIND_ACK, '0, '0, '0, dropped, 1'b1};
    await_result(res);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("[cycle %0d] mismatch on %s: got %0h, expected %0h",
             cycle_count, what, got, want);
    mismatches++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [REGION_W-1:0] rand_region();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return REGION_W'({$urandom, $urandom});
    endcase
  endfunction

  task automatic add_req(input longint frame, input logic [OWNER_W-1:0] owner,
                         input logic [REGION_W-1:0] offset,
                         input logic [REGION_W-1:0] size, input bit drain_first);
    free_req_t req;
    req = '{FRAME_W'(frame), owner, offset, size, drain_first};
    free_reqs.insert(free_reqs.size(), req);
  endtask

  // Mostly frames creeping forward at a pace that suits wait_frames, with the
  // odd step backwards and the odd leap that can flush the whole FIFO.
  task automatic queue_random(input int n, input int step_max);
    int pick;
    int delta;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        delta = $urandom_range(1, wait_cfg + 3);
        frame_now = frame_now - delta;
      end else if (pick < 5) begin
        delta = $urandom_range(1, 65536);
        frame_now = frame_now + delta;
      end else begin
        delta = $urandom_range(0, step_max);
        frame_now = frame_now + delta;
      end
      if (frame_now < 0) frame_now = 0;
      if (frame_now > FRAME_MAX) frame_now = FRAME_MAX;
      add_req(frame_now, OWNER_W'($urandom), rand_region(), rand_region(),
              $urandom_range(0, 39) == 0);
    end
  endtask

  // APB-style access: setup cycle, then access cycle completed on pready
  task automatic cfg_access(input bit write, input logic [CFG_ADDR_W-1:0] addr,
                            input logic [CFG_DATA_W-1:0] data,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    if (write && addr == frdq_pkg::ADDR_WAIT_FRAMES) wait_cfg = data[WAIT_W-1:0];
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // nothing left to offer, nothing on the wire, nothing awaited
  task automatic drain_and_settle();
    while (free_reqs.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of transactions separated by random gaps. A stalled
  // transaction is held unchanged; the shadow is stepped at the accept edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid   <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (in_valid && !in_stall) predict_free(cur_req);

      if (in_valid && in_stall) begin
        // hold the payload until it is taken
      end else if (gap_left != 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (free_reqs.size() != 0 &&
                   !(free_reqs[0].drain_first && awaited_results.size() != 0)) begin
        cur_req = free_reqs.pop_front();
        in_valid         <= 1'b1;
        in_frame_number  <= cur_req.frame;
        in_owner_id      <= cur_req.owner;
        in_region_offset <= cur_req.offset;
        in_region_size   <= cur_req.size;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest awaited one and
  // drives out_stall from a randomly chosen stall pattern.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_mode <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected result transaction", out_kind, 1'b0);
        end else begin
          head_result = awaited_results.pop_front();
          check_field("kind",       out_kind,       head_result.kind);
          check_field("owner",      out_owner,      head_result.owner);
          check_field("offset",     out_offset,     head_result.offset);
          check_field("size",       out_size,       head_result.size);
          check_field("queue_full", out_queue_full, head_result.full);
          check_field("last",       out_last,       head_result.last);
        end
      end

      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(20, 200);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0:       out_stall <= 1'b0;
        1:       out_stall <= ($urandom_range(0, 99) < 30);
        2:       out_stall <= ($urandom_range(0, 99) < 75);
        default: out_stall <= ((cycle_count % 5) < 2);
      endcase
    end
  end

  // watchdog
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed requests at the reset wait_frames, then random
  // phases each preceded by a wait_frames write and read-back while idle.
  // ---------------------------------------------------------------------------
  initial begin
    int                    wait_set  [5];
    int                    step_set  [5];
    longint                floor_set [5];
    logic [CFG_DATA_W-1:0] rdata;

    reset_shadow();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // wait_frames is 2 out of reset
    add_req(0, '0, '0, '0, 1'b0);                 // empty FIFO, gate at 0
    add_req(0, '1, '1, '1, 1'b0);                 // head too young: gate moves to 3
    add_req(2, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0); // gate not reached
    add_req(3, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0); // partial release
    add_req(10, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0); // all released
    for (int i = 0; i < 15; i++)                  // fill the FIFO
      add_req(10, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0);
    add_req(10, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0); // dropped: full
    add_req(5, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0);  // going backwards
    add_req(100, OWNER_W'($urandom), rand_region(), rand_region(), 1'b1); // full flush
    add_req(100, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0);
    add_req(103, OWNER_W'($urandom), rand_region(), rand_region(), 1'b0);

    // phase settings: wait_frames, frame step, lowest starting frame
    wait_set[0] = 0;   step_set[0] = 2;  floor_set[0] = 200;
    wait_set[1] = 255; step_set[1] = 48; floor_set[1] = 0;
    wait_set[2] = $urandom_range(1, 254);
    step_set[2] = wait_set[2] / 4 + 2;   floor_set[2] = 0;
    wait_set[3] = 1;   step_set[3] = 2;
    floor_set[3] = (longint'(1) << 24) + $urandom_range(0, 65535);
    wait_set[4] = $urandom_range(0, 16);
    step_set[4] = 8;   floor_set[4] = FRAME_MAX - 3000; // runs into the top frame

    for (int p = 0; p < 5; p++) begin
      drain_and_settle();
      cfg_access(1'b1, frdq_pkg::ADDR_WAIT_FRAMES, CFG_DATA_W'(wait_set[p]), rdata);
      cfg_access(1'b0, frdq_pkg::ADDR_WAIT_FRAMES, '0, rdata);
      check_field("wait_frames read-back", rdata[WAIT_W-1:0], wait_cfg);
      if (frame_now < floor_set[p]) frame_now = floor_set[p];
      queue_random(PHASE_ITEMS, step_set[p]);
    end

    drain_and_settle();
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
